>>> hdl/spmf_pkg.sv
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared operation and status codes for the strict priority ticket queues.
// ----------------------------------------------------------------------------
package spmf_pkg;

  // operation requested by one input beat
  typedef enum logic [1:0] {
    FUNC_TAKE     = 2'd0,
    FUNC_ENQ      = 2'd1,
    FUNC_SERVE    = 2'd2,
    FUNC_SERVE_HI = 2'd3
  } func_t;

  // status reported with each result beat
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_t;

  // fixed field widths of the result beat
  localparam int TicketW = 16;
  localparam int CountW  = 5;
  localparam int TotalW  = 6;

endpackage

>>> hdl/strict_priority_multi_fifo.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Ticket dispenser with CLASS_COUNT strict priority FIFO rings of tickets.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | func, service_class, ticket_in
//  out     | out_valid / out_stall | ticket_out, status, served_class,
//          |                       | count_class0..2, count_total
//
//  One beat is taken every cycle unless in_stall is high; an accepted beat
//  passes through the stage 1 register and then the result register, stage 1
//  waiting on the registered read of the shared ticket RAM.
//  Pointers, counts and the ticket counter update at the accepting edge, so
//  back-to-back beats always see the state left by the previous one.
//  Reset clears pointers, counts and both stage valids and sets the ticket
//  counter to 1; RAM contents are not reset and are only read once written.
//  out_stall holds the result register and the stage before it, and in_stall
//  rises only when both are full.
//
module strict_priority_multi_fifo #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CLASS_COUNT = 3,
  parameter int TICKET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [1:0]  service_class,
  input  logic [15:0] ticket_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] ticket_out,
  output logic [1:0]  status,
  output logic [1:0]  served_class,
  output logic [4:0]  count_class0,
  output logic [4:0]  count_class1,
  output logic [4:0]  count_class2,
  output logic [5:0]  count_total
);

  localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int ClsW   = $clog2(CLASS_COUNT);
  localparam int Slots  = CLASS_COUNT * QUEUE_DEPTH;
  localparam int AddrW  = $clog2(Slots);
  localparam int SumW   = $clog2(Slots + 1);
  localparam int TkW    = (TICKET_BITS > spmf_pkg::TicketW) ? TICKET_BITS : spmf_pkg::TicketW;
  localparam int CntXW  = (CntW > spmf_pkg::CountW) ? CntW : spmf_pkg::CountW;
  localparam int SumXW  = (SumW > spmf_pkg::TotalW) ? SumW : spmf_pkg::TotalW;
  localparam int SrvXW  = (ClsW > 2) ? ClsW : 2;

  localparam logic [PtrW-1:0]        PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0]        CntFull = CntW'(QUEUE_DEPTH);
  localparam logic [TICKET_BITS-1:0] TkMax   = {TICKET_BITS{1'b1}};
  localparam logic [TICKET_BITS-1:0] TkOne   = TICKET_BITS'(1);

  // queue state
  logic [PtrW-1:0]        head      [CLASS_COUNT];
  logic [PtrW-1:0]        head_next [CLASS_COUNT];
  logic [PtrW-1:0]        tail      [CLASS_COUNT];
  logic [PtrW-1:0]        tail_next [CLASS_COUNT];
  logic [CntW-1:0]        cnt       [CLASS_COUNT];
  logic [CntW-1:0]        cnt_next  [CLASS_COUNT];
  logic [TICKET_BITS-1:0] ticket;
  logic [TICKET_BITS-1:0] ticket_next;

  // handshake
  logic in_accept;
  logic s1_adv;
  logic out_load;

  // decode of the current beat
  logic                  cls_ok;
  logic [ClsW-1:0]       cls_idx;
  logic                  hi_found;
  logic [ClsW-1:0]       hi_cls;
  logic                  do_pop;
  logic                  do_push;
  logic [ClsW-1:0]       pop_cls;
  spmf_pkg::status_t     st;
  logic [15:0]           tkt;
  logic [TkW-1:0]        tkt_wide;
  logic [SumW-1:0]       sum;
  logic [AddrW-1:0]      wr_addr;
  logic [AddrW-1:0]      rd_addr;
  logic [15:0]           rd_data;

  // stage 1 register
  logic                  s1_valid;
  logic                  s1_pop;
  logic [15:0]           s1_ticket;
  spmf_pkg::status_t     s1_status;
  logic [1:0]            s1_served;
  logic [4:0]            s1_cnt [3];
  logic [5:0]            s1_total;

  // formatted results
  logic [1:0]            srv_fmt;
  logic [SrvXW-1:0]      srv_wide;
  logic [4:0]            cnt_fmt [3];
  logic [CntXW-1:0]      cnt_wide [3];
  logic [SumXW-1:0]      sum_wide;

  // flow control across the two registers
  assign out_load  = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_load;
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = s1_valid && !out_load;

  // class decode
  assign cls_ok  = (32'(service_class) < CLASS_COUNT);
  assign cls_idx = ClsW'(service_class);

  // highest priority class that holds an entry
  always_comb begin
    hi_found = 1'b0;
    hi_cls   = '0;
    for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
      if (cnt[c] != '0) begin
        hi_found = 1'b1;
        hi_cls   = ClsW'(c);
      end
    end
  end

  assign tkt_wide = TkW'(ticket);

  // operation decode and next state
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    cnt_next    = cnt;
    ticket_next = ticket;
    do_pop      = 1'b0;
    do_push     = 1'b0;
    pop_cls     = cls_idx;
    st          = spmf_pkg::ST_OK;
    tkt         = '0;
    case (spmf_pkg::func_t'(func))
      spmf_pkg::FUNC_TAKE: begin
        tkt         = tkt_wide[15:0];
        ticket_next = (ticket == TkMax) ? TkOne : ticket + TkOne;
      end
      spmf_pkg::FUNC_ENQ: begin
        if (!cls_ok) begin
          st = spmf_pkg::ST_BAD_CLASS;
        end else if (cnt[cls_idx] == CntFull) begin
          st = spmf_pkg::ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      spmf_pkg::FUNC_SERVE: begin
        if (!cls_ok) begin
          st = spmf_pkg::ST_BAD_CLASS;
        end else if (cnt[cls_idx] == '0) begin
          st = spmf_pkg::ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      spmf_pkg::FUNC_SERVE_HI: begin
        if (hi_found) begin
          do_pop  = 1'b1;
          pop_cls = hi_cls;
        end else begin
          st = spmf_pkg::ST_EMPTY;
        end
      end
      default: begin
        st = spmf_pkg::ST_EMPTY;
      end
    endcase
    if (do_push) begin
      tail_next[cls_idx] = (tail[cls_idx] == PtrLast) ? '0 : tail[cls_idx] + PtrW'(1);
      cnt_next[cls_idx]  = cnt[cls_idx] + CntW'(1);
    end
    if (do_pop) begin
      head_next[pop_cls] = (head[pop_cls] == PtrLast) ? '0 : head[pop_cls] + PtrW'(1);
      cnt_next[pop_cls]  = cnt[pop_cls] - CntW'(1);
    end
  end

  // RAM addresses: class base plus ring pointer
  assign wr_addr = AddrW'(cls_idx) * AddrW'(QUEUE_DEPTH) + AddrW'(tail[cls_idx]);
  assign rd_addr = AddrW'(pop_cls) * AddrW'(QUEUE_DEPTH) + AddrW'(head[pop_cls]);

  spmf_ram #(
    .WIDTH (16),
    .DEPTH (Slots)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_accept && do_push),
    .wr_addr (wr_addr),
    .wr_data (ticket_in),
    .rd_en   (in_accept && do_pop),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // counts after this beat
  always_comb begin
    sum = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      sum = sum + SumW'(cnt_next[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cnt_wide[c] = '0;
      if (c < CLASS_COUNT) begin
        cnt_wide[c] = CntXW'(cnt_next[c]);
      end
      cnt_fmt[c] = cnt_wide[c][4:0];
    end
  end

  assign sum_wide = SumXW'(sum);
  assign srv_wide = do_pop ? SrvXW'(pop_cls) : '0;
  assign srv_fmt  = srv_wide[1:0];

  // queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        cnt[c]  <= '0;
      end
      ticket <= TkOne;
    end else if (in_accept) begin
      head   <= head_next;
      tail   <= tail_next;
      cnt    <= cnt_next;
      ticket <= ticket_next;
    end
  end

  // stage 1: decoded result waiting for RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pop    <= do_pop;
      s1_ticket <= tkt;
      s1_status <= st;
      s1_served <= srv_fmt;
      s1_cnt    <= cnt_fmt;
      s1_total  <= sum_wide[5:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      ticket_out   <= s1_pop ? rd_data : s1_ticket;
      status       <= s1_status;
      served_class <= s1_served;
      count_class0 <= s1_cnt[0];
      count_class1 <= s1_cnt[1];
      count_class2 <= s1_cnt[2];
      count_total  <= s1_total;
    end
  end

endmodule

>>> hdl/spmf_ram.sv
// ----------------------------------------------------------------------------
// spmf_ram
// Simple dual-port RAM, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module spmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/spmf_checker.sv
// ----------------------------------------------------------------------------
// spmf_checker
// Port-level checks on the result beats of the priority ticket queues.
// ----------------------------------------------------------------------------
module spmf_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] ticket_out,
  input logic [1:0]  status,
  input logic [1:0]  served_class,
  input logic [4:0]  count_class0,
  input logic [4:0]  count_class1,
  input logic [4:0]  count_class2
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ticket_out) && $stable(status)
      && $stable(served_class))
    else $error("stalled result beat changed");

  // errors carry no ticket
  a_err_no_ticket: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != spmf_pkg::ST_OK) |-> ticket_out == 16'd0)
    else $error("ticket reported with error status");

  // served class only on a successful serve
  a_err_no_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != spmf_pkg::ST_OK) |-> served_class == 2'd0)
    else $error("served class reported with error status");

  // counts never exceed the ring depth, checked for depths below 32
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && (QUEUE_DEPTH < 32) |-> 32'(count_class0) <= QUEUE_DEPTH
      && 32'(count_class1) <= QUEUE_DEPTH && 32'(count_class2) <= QUEUE_DEPTH)
    else $error("class count above ring depth");

endmodule

bind strict_priority_multi_fifo spmf_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spmf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .ticket_out   (ticket_out),
  .status       (status),
  .served_class (served_class),
  .count_class0 (count_class0),
  .count_class1 (count_class1),
  .count_class2 (count_class2)
);
